// File: hw/rtl/dhoe_pkg.sv
// DHCP option extractor: shared types and constants.
// Result kinds, option codes, cookie table and result structs.
// No dependencies.
package dhoe_pkg;

    // result kinds
    localparam logic [3:0] KIND_MSGTYPE = 4'd0;
    localparam logic [3:0] KIND_SID     = 4'd1;
    localparam logic [3:0] KIND_LEASE   = 4'd2;
    localparam logic [3:0] KIND_MASK    = 4'd3;
    localparam logic [3:0] KIND_ROUTER  = 4'd4;
    localparam logic [3:0] KIND_DNS     = 4'd5;
    localparam logic [3:0] KIND_NAME    = 4'd6;
    localparam logic [3:0] KIND_END     = 4'd7;
    localparam logic [3:0] KIND_BADCK   = 4'd8;
    localparam logic [3:0] KIND_TRUNC   = 4'd9;

    // option codes
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_MASK      = 8'd1;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_DNS       = 8'd6;
    localparam logic [7:0] OPT_DOMAIN    = 8'd15;
    localparam logic [7:0] OPT_LEASE     = 8'd51;
    localparam logic [7:0] OPT_MSGTYPE   = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'd255;

    typedef struct packed {
        logic [3:0]  item_kind;
        logic [31:0] item_value;
        logic        element_last;
        logic        run_last;
    } res_item_t;

    // what one accepted byte produces: up to two results, item0 first
    typedef struct packed {
        logic [1:0] count;
        res_item_t  item0;
        res_item_t  item1;
    } parse_res_t;

    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'd99;
            2'd1:    b = 8'd130;
            2'd2:    b = 8'd83;
            default: b = 8'd99;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/dhoe_if.sv
// DHCP option extractor: valid/ready channel interfaces.
// Byte channel in, result channel out. No dependencies.
interface dhoe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       first_byte;
    logic       final_byte;

    modport source (output valid, opt_byte, first_byte, final_byte, input ready);
    modport sink   (input valid, opt_byte, first_byte, final_byte, output ready);
endinterface

interface dhoe_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  item_kind;
    logic [31:0] item_value;
    logic        element_last;
    logic        run_last;

    modport source (output valid, item_kind, item_value, element_last, run_last,
                    input ready);
    modport sink   (input valid, item_kind, item_value, element_last, run_last,
                    output ready);
endinterface

// File: hw/rtl/dhcp_option_extractor.sv
// DHCP option extractor, top level: option parser plus a four-entry result queue.
// Depends on dhoe_pkg, dhoe_if (dhoe_byte_if, dhoe_res_if) and dhoe_parser.
//
//   channel | dir | fields                                         | request
//   opt     | in  | opt_byte[7:0] first_byte final_byte            | one options byte
//   res     | out | item_kind[3:0] item_value[31:0] element_last   | one result item
//           |     | run_last                                       |
//
// Cycles: a byte is parsed in the cycle it is accepted; its results (none, one
//   or two) sit in the queue and can leave from the next cycle on.
// Rate: one byte per cycle while the queue has room for two results; a byte
//   producing two results must hand both to the result port, so the result port sets the pace.
// Stalls: opt.ready drops while more than two results are queued.
// Reset: rst_n (async, active low) empties the queue and puts the parser back
//   to the cookie check.
module dhcp_option_extractor
    import dhoe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    dhoe_byte_if.sink  opt,
    dhoe_res_if.source res
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    res_item_t     q_mem [DEPTH];
    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [PW:0]   cnt_reg,  cnt_next;

    logic       accept;
    logic       pop;
    parse_res_t pres;
    res_item_t  head_item;

    // room for the worst case of two results per byte
    assign opt.ready = (cnt_reg <= (PW+1)'(DEPTH - 2));
    assign accept    = opt.valid && opt.ready;

    dhoe_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .opt_byte   (opt.opt_byte),
        .first_byte (opt.first_byte),
        .final_byte (opt.final_byte),
        .res        (pres)
    );

    // queue bookkeeping
    assign pop = res.valid && res.ready;

    always_comb
    begin
        head_next = head_reg + PW'(pop);
        tail_next = tail_reg;
        cnt_next  = cnt_reg - (PW+1)'(pop);
        if (accept)
        begin
            tail_next = tail_reg + pres.count[PW-1:0];
            cnt_next  = cnt_next + (PW+1)'(pres.count);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && (pres.count != 2'd0))
            q_mem[tail_reg] <= pres.item0;
        if (accept && (pres.count == 2'd2))
            q_mem[tail_reg + PW'(1)] <= pres.item1;
    end

    assign head_item        = q_mem[head_reg];
    assign res.valid        = (cnt_reg != '0);
    assign res.item_kind    = head_item.item_kind;
    assign res.item_value   = head_item.item_value;
    assign res.element_last = head_item.element_last;
    assign res.run_last     = head_item.run_last;

`ifndef SYNTHESIS
    // queue never overfills
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(DEPTH))
        else $error("result queue overfilled");

    // a full-ish queue must hold off the byte channel
    a_hold_off: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg > (PW+1)'(DEPTH - 2)) |-> !opt.ready)
        else $error("byte accepted without room for two results");

    // truncation is always the final result of its byte
    a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.item_kind == KIND_TRUNC) |-> res.run_last)
        else $error("truncated result not marked as last of its byte");

    // element_last only on list entries and name bytes
    a_elast_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.element_last) |->
        (res.item_kind == KIND_ROUTER || res.item_kind == KIND_DNS ||
         res.item_kind == KIND_NAME))
        else $error("element_last on a scalar result");
`endif

endmodule

// File: hw/rtl/dhoe_parser.sv
// DHCP option extractor: option walk state and per-byte result logic.
// Depends on dhoe_pkg.
module dhoe_parser
    import dhoe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] opt_byte,
    input  logic       first_byte,
    input  logic       final_byte,
    output parse_res_t res
);

    localparam logic [2:0] PH_COOKIE = 3'd0;
    localparam logic [2:0] PH_CODE   = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  cidx_reg,  cidx_next;
    logic [7:0]  code_reg,  code_next;
    logic [7:0]  left_reg,  left_next;
    logic [1:0]  grp_reg,   grp_next;
    logic [31:0] va_reg,    va_next;

    // state as seen by this byte (a first byte restarts the walk)
    logic [2:0]  ph;
    logic [1:0]  ci;
    logic [7:0]  code;
    logic [7:0]  left;
    logic [1:0]  grp;
    logic [31:0] va;

    logic [7:0]  left_dec;
    logic [31:0] va_sh;
    logic        grp_done;
    logic        p_valid;
    logic        t_valid;
    res_item_t   prim;
    res_item_t   trunc;

    always_comb
    begin
        ph   = first_byte ? PH_COOKIE : phase_reg;
        ci   = first_byte ? 2'd0  : cidx_reg;
        code = first_byte ? 8'd0  : code_reg;
        left = first_byte ? 8'd0  : left_reg;
        grp  = first_byte ? 2'd0  : grp_reg;
        va   = first_byte ? 32'd0 : va_reg;

        left_dec = left - 8'd1;
        va_sh    = {va[23:0], opt_byte};
        grp_done = (grp == 2'd3);

        phase_next = ph;
        cidx_next  = ci;
        code_next  = code;
        left_next  = left;
        grp_next   = grp;
        va_next    = va;

        p_valid = 1'b0;
        prim    = '0;

        case (ph)
            PH_COOKIE:
            begin
                if (opt_byte != cookie_byte(ci))
                begin
                    p_valid        = 1'b1;
                    prim.item_kind = KIND_BADCK;
                    phase_next     = PH_DONE;
                end
                else if (ci == 2'd3)
                begin
                    phase_next = PH_CODE;
                    cidx_next  = 2'd0;
                end
                else
                begin
                    cidx_next = ci + 2'd1;
                end
            end
            PH_CODE:
            begin
                if (opt_byte == OPT_END)
                begin
                    p_valid        = 1'b1;
                    prim.item_kind = KIND_END;
                    phase_next     = PH_DONE;
                end
                else if (opt_byte != OPT_PAD)
                begin
                    code_next  = opt_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                left_next  = opt_byte;
                grp_next   = 2'd0;
                va_next    = 32'd0;
                phase_next = (opt_byte == 8'd0) ? PH_CODE : PH_DATA;
            end
            PH_DATA:
            begin
                left_next = left_dec;
                va_next   = va_sh;
                grp_next  = grp + 2'd1;
                case (code)
                    OPT_MSGTYPE:
                    begin
                        p_valid         = 1'b1;
                        prim.item_kind  = KIND_MSGTYPE;
                        prim.item_value = {24'd0, opt_byte};
                        phase_next      = PH_SKIP;
                    end
                    OPT_SERVER_ID, OPT_LEASE, OPT_MASK:
                    begin
                        if (grp_done)
                        begin
                            p_valid         = 1'b1;
                            prim.item_value = va_sh;
                            if (code == OPT_SERVER_ID)
                                prim.item_kind = KIND_SID;
                            else if (code == OPT_LEASE)
                                prim.item_kind = KIND_LEASE;
                            else
                                prim.item_kind = KIND_MASK;
                            phase_next = PH_SKIP;
                        end
                    end
                    OPT_ROUTER, OPT_DNS:
                    begin
                        if (grp_done)
                        begin
                            p_valid           = 1'b1;
                            prim.item_kind    = (code == OPT_ROUTER) ? KIND_ROUTER : KIND_DNS;
                            prim.item_value   = va_sh;
                            prim.element_last = (left_dec < 8'd4);
                        end
                    end
                    OPT_DOMAIN:
                    begin
                        p_valid           = 1'b1;
                        prim.item_kind    = KIND_NAME;
                        prim.item_value   = {24'd0, opt_byte};
                        prim.element_last = (left_dec == 8'd0);
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
                if (left_dec == 8'd0)
                    phase_next = PH_CODE;
            end
            PH_SKIP:
            begin
                left_next = left_dec;
                if (left_dec == 8'd0)
                    phase_next = PH_CODE;
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase

        // area ends without END
        t_valid         = final_byte && (phase_next != PH_DONE);
        trunc           = '0;
        trunc.item_kind = KIND_TRUNC;
        trunc.run_last  = 1'b1;
        if (t_valid)
            phase_next = PH_DONE;

        prim.run_last = !t_valid;

        res.count = {1'b0, p_valid} + {1'b0, t_valid};
        res.item0 = p_valid ? prim : trunc;
        res.item1 = trunc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_COOKIE;
            cidx_reg  <= 2'd0;
            code_reg  <= 8'd0;
            left_reg  <= 8'd0;
            grp_reg   <= 2'd0;
            va_reg    <= 32'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cidx_reg  <= cidx_next;
            code_reg  <= code_next;
            left_reg  <= left_next;
            grp_reg   <= grp_next;
            va_reg    <= va_next;
        end
    end

endmodule

// File: sim/dhcp_option_extractor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for dhcp_option_extractor: byte stream in, extracted options out.
// Depends on dhoe_pkg, dhoe_if (dhoe_byte_if, dhoe_res_if) and the extractor RTL.
module dhcp_option_extractor_tb;
    import dhoe_pkg::*;

    // Cookie bytes in wire order, most significant first: 99, 130, 83, 99.
    localparam logic [31:0] MAGIC_COOKIE = 32'h63825363;

    // Where the option walk stands; mirrors the parser's own phases.
    typedef enum logic [2:0] {
        WALK_COOKIE,
        WALK_CODE,
        WALK_LEN,
        WALK_DATA,
        WALK_SKIP,
        WALK_DONE
    } walk_phase_e;

    logic clk;
    logic rst_n;

    dhoe_byte_if opt_if ();
    dhoe_res_if  res_if ();

    dhcp_option_extractor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .opt   (opt_if),
        .res   (res_if)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the parser state
    // ------------------------------------------------------------------
    walk_phase_e walk_phase;
    logic [1:0]  ck_idx;
    logic [7:0]  cur_code;
    logic [7:0]  left;
    logic [1:0]  grp;
    logic [31:0] acc;

    res_item_t   expected_extracts[$];   // oldest at the front
    logic [7:0]  pkt_bytes[$];           // packet under construction
    int          fail_count;
    int          bytes_sent;
    bit          idle_on;                // random gaps on both channels
    int          hold_cycles_req;        // long sink hold-off, picked up by the sink

    function automatic void walk_reset();
        walk_phase = WALK_COOKIE;
        ck_idx     = 2'd0;
        cur_code   = 8'd0;
        left       = 8'd0;
        grp        = 2'd0;
        acc        = 32'd0;
    endfunction

    function automatic res_item_t result_of(input logic [3:0] kind, input logic [31:0] value,
                                            input logic el);
        res_item_t r;
        r.item_kind    = kind;
        r.item_value   = value;
        r.element_last = el;
        r.run_last     = 1'b0;
        return r;
    endfunction

    // Advance the shadow walk by one accepted byte and queue what it yields.
    function automatic void predict_extracts(input logic [7:0] b, input logic is_first,
                                             input logic is_last);
        res_item_t made[$];
        logic      grp_done;
        if (is_first)
            walk_reset();
        case (walk_phase)
            WALK_COOKIE:
            begin
                if (b != MAGIC_COOKIE[(3 - int'(ck_idx)) * 8 +: 8])
                begin
                    made.push_back(result_of(KIND_BADCK, 32'd0, 1'b0));
                    walk_phase = WALK_DONE;
                end
                else if (ck_idx == 2'd3)
                begin
                    walk_phase = WALK_CODE;
                    ck_idx     = 2'd0;
                end
                else
                    ck_idx = ck_idx + 2'd1;
            end
            WALK_CODE:
            begin
                if (b == OPT_END)
                begin
                    made.push_back(result_of(KIND_END, 32'd0, 1'b0));
                    walk_phase = WALK_DONE;
                end
                else if (b != OPT_PAD)
                begin
                    cur_code   = b;
                    walk_phase = WALK_LEN;
                end
            end
            WALK_LEN:
            begin
                left       = b;
                grp        = 2'd0;
                acc        = 32'd0;
                walk_phase = (b == 8'd0) ? WALK_CODE : WALK_DATA;
            end
            WALK_DATA:
            begin
                left     = left - 8'd1;
                acc      = {acc[23:0], b};
                grp_done = (grp == 2'd3);
                grp      = grp + 2'd1;
                case (cur_code)
                    OPT_MSGTYPE:
                    begin
                        // only the first byte counts, rest is skipped
                        made.push_back(result_of(KIND_MSGTYPE, {24'd0, b}, 1'b0));
                        walk_phase = WALK_SKIP;
                    end
                    OPT_SERVER_ID, OPT_LEASE, OPT_MASK:
                    begin
                        if (grp_done)
                        begin
                            made.push_back(result_of(cur_code == OPT_SERVER_ID ? KIND_SID :
                                                     cur_code == OPT_LEASE ? KIND_LEASE :
                                                     KIND_MASK, acc, 1'b0));
                            walk_phase = WALK_SKIP;
                        end
                    end
                    OPT_ROUTER, OPT_DNS:
                    begin
                        // last flag once no further whole address can follow
                        if (grp_done)
                            made.push_back(result_of(cur_code == OPT_ROUTER ? KIND_ROUTER :
                                                     KIND_DNS, acc, left < 8'd4));
                    end
                    OPT_DOMAIN:
                        made.push_back(result_of(KIND_NAME, {24'd0, b}, left == 8'd0));
                    default:
                        walk_phase = WALK_SKIP;
                endcase
                if (left == 8'd0)
                    walk_phase = WALK_CODE;
            end
            WALK_SKIP:
            begin
                left = left - 8'd1;
                if (left == 8'd0)
                    walk_phase = WALK_CODE;
            end
            default:
                walk_phase = WALK_DONE;
        endcase
        // area ended with no END and no cookie failure: truncated goes last
        if (is_last && walk_phase != WALK_DONE)
        begin
            made.push_back(result_of(KIND_TRUNC, 32'd0, 1'b0));
            walk_phase = WALK_DONE;
        end
        if (made.size() > 0)
            made[made.size() - 1].run_last = 1'b1;
        foreach (made[i])
            expected_extracts.push_back(made[i]);
    endfunction

    // ------------------------------------------------------------------
    // Byte sender: optional gap, then hold the request until accepted.
    // Called and returns on a rising edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            opt_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        opt_if.valid      <= 1'b1;
        opt_if.opt_byte   <= b;
        opt_if.first_byte <= is_first;
        opt_if.final_byte <= is_last;
        do
            @(posedge clk);
        while (!opt_if.ready);
        predict_extracts(b, is_first, is_last);
        bytes_sent++;
    endtask

    task automatic send_packet(input bit mark_final);
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == 0, mark_final && i == pkt_bytes.size() - 1);
    endtask

    task automatic push_cookie();
        for (int k = 0; k < 4; k++)
            pkt_bytes.push_back(MAGIC_COOKIE[(3 - k) * 8 +: 8]);
    endtask

    function automatic logic [7:0] data_value();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One option with a random code and length; lengths are mostly short,
    // now and then a long one to push the length byte to its top bits.
    task automatic push_random_option();
        logic [7:0] code;
        int         len;
        case ($urandom_range(0, 9))
            0:       code = OPT_PAD;
            1:       code = OPT_MSGTYPE;
            2:       code = OPT_SERVER_ID;
            3:       code = OPT_LEASE;
            4:       code = OPT_MASK;
            5:       code = OPT_ROUTER;
            6:       code = OPT_DNS;
            7:       code = OPT_DOMAIN;
            default: code = 8'($urandom_range(2, 254));
        endcase
        pkt_bytes.push_back(code);
        if (code != OPT_PAD)
        begin
            if ($urandom_range(0, 60) == 0)
                len = $urandom_range(200, 255);
            else if ($urandom_range(0, 3) == 0)
                len = $urandom_range(0, 3);
            else
                len = $urandom_range(4, 13);
            pkt_bytes.push_back(8'(len));
            repeat (len) pkt_bytes.push_back(data_value());
        end
    endtask

    // Mostly well-formed option areas with random content; some with a broken
    // cookie, some cut short, some without a final flag, a few pure noise.
    task automatic send_random_packet();
        int  bad_pos;
        int  ending;
        bit  mark_final;
        pkt_bytes.delete();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            send_packet(1'($urandom_range(0, 1)));
            return;
        end
        bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
        for (int k = 0; k < 4; k++)
            pkt_bytes.push_back(MAGIC_COOKIE[(3 - k) * 8 +: 8] ^
                                (k == bad_pos ? 8'($urandom_range(1, 255)) : 8'd0));
        repeat ($urandom_range(0, 6)) push_random_option();
        ending = $urandom_range(0, 9);
        if (ending < 7)
        begin
            pkt_bytes.push_back(OPT_END);
            // bytes after END are ignored by the parser
            repeat ($urandom_range(0, 2)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
            mark_final = 1'($urandom_range(0, 1));
        end
        else if (ending < 9)
        begin
            repeat ($urandom_range(0, 3))
                if (pkt_bytes.size() > 1)
                    void'(pkt_bytes.pop_back());
            mark_final = 1'b1;
        end
        else
            mark_final = 1'b0;     // the next first byte restarts the walk
        send_packet(mark_final);
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // PAD, message type, short mask, then the area ends with no END.
    task automatic test_truncated_walk();
        pkt_bytes.delete();
        push_cookie();
        pkt_bytes.push_back(OPT_PAD);
        pkt_bytes.push_back(OPT_MSGTYPE);
        pkt_bytes.push_back(8'd1);
        pkt_bytes.push_back(8'd5);
        pkt_bytes.push_back(OPT_MASK);
        pkt_bytes.push_back(8'd2);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        send_packet(1'b1);
    endtask

    // Cookie fails on its second byte; the following byte is ignored even
    // though it carries the final flag.
    task automatic test_bad_cookie();
        send_byte(8'd99, 1'b1, 1'b0);
        send_byte(8'd7, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
    endtask

    // Router list with a dangling byte, one name byte, zero-length DNS, END.
    task automatic test_lists_and_end();
        pkt_bytes.delete();
        push_cookie();
        pkt_bytes.push_back(OPT_ROUTER);
        pkt_bytes.push_back(8'd5);
        pkt_bytes.push_back(8'd10);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(8'd1);
        pkt_bytes.push_back(8'd9);
        pkt_bytes.push_back(OPT_DOMAIN);
        pkt_bytes.push_back(8'd1);
        pkt_bytes.push_back(8'h61);
        pkt_bytes.push_back(OPT_DNS);
        pkt_bytes.push_back(8'd0);
        pkt_bytes.push_back(OPT_END);
        send_packet(1'b0);
    endtask

    task automatic test_random_packets();
        int target;
        target = bytes_sent + 440;
        while (bytes_sent < target)
        begin
            // some packets run back to back, others with gaps
            idle_on = ($urandom_range(0, 3) != 0);
            send_random_packet();
        end
    endtask

    // Sink holds off for a long stretch while a long domain name streams in,
    // so the result queue fills and the byte input stalls.
    task automatic test_backpressure();
        idle_on         = 1'b0;
        hold_cycles_req = 120;
        pkt_bytes.delete();
        push_cookie();
        pkt_bytes.push_back(OPT_DOMAIN);
        pkt_bytes.push_back(8'd40);
        repeat (40) pkt_bytes.push_back(data_value());
        pkt_bytes.push_back(OPT_END);
        send_packet(1'b1);
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_quiet_tail();
        int target;
        idle_on = 1'b0;
        target  = bytes_sent + 60;
        while (bytes_sent < target)
            send_random_packet();
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int stall_left;
        stall_left   = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_req != 0)
            begin
                stall_left      = hold_cycles_req;
                hold_cycles_req = 0;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 8);
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // Every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin : extract_checker
        res_item_t got;
        res_item_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.item_kind    = res_if.item_kind;
            got.item_value   = res_if.item_value;
            got.element_last = res_if.element_last;
            got.run_last     = res_if.run_last;
            if (expected_extracts.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d value %h elast %0b rlast %0b",
                         $time, got.item_kind, got.item_value, got.element_last,
                         got.run_last);
                fail_count++;
            end
            else
            begin
                want = expected_extracts.pop_front();
                if (got !== want)
                begin
                    // kind/value/elast/rlast
                    $display("%0t: expected %0d/%h/%0b/%0b, got %0d/%h/%0b/%0b",
                             $time, want.item_kind, want.item_value, want.element_last,
                             want.run_last, got.item_kind, got.item_value,
                             got.element_last, got.run_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        int waited;
        opt_if.valid      = 1'b0;
        opt_if.opt_byte   = 8'd0;
        opt_if.first_byte = 1'b0;
        opt_if.final_byte = 1'b0;
        rst_n             = 1'b0;
        fail_count        = 0;
        bytes_sent        = 0;
        idle_on           = 1'b1;
        hold_cycles_req   = 0;
        walk_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_truncated_walk();
        test_bad_cookie();
        test_lists_and_end();
        test_random_packets();
        test_backpressure();
        test_quiet_tail();
        opt_if.valid <= 1'b0;

        // drain, then keep watching for anything stray
        waited = 0;
        while (expected_extracts.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (expected_extracts.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_extracts.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
